[rtl/core/plhe_pkg.sv]
// shared types, constants and helper functions of the path label hex escape codec
package plhe_pkg;

  localparam logic [7:0] Underscore = 8'h5f;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhUs   = 2'd1;
  localparam logic [1:0] PhHex  = 2'd2;

  localparam logic DirEscape   = 1'b0;
  localparam logic DirUnescape = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       label_end;
    logic       label_error;
  } res_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] held;
    logic       at_start;
  } lbl_state_t;

  localparam lbl_state_t LblClear = '{phase: PhIdle, held: 8'h00, at_start: 1'b1};

  function automatic res_t mk_res(logic [7:0] b, logic valid, logic lend, logic err);
    res_t r;
    r.out_byte    = valid ? b : 8'h00;
    r.byte_valid  = valid;
    r.label_end   = lend;
    r.label_error = err;
    return r;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b inside {[8'h30:8'h39]}) v = {1'b0, 4'(b - 8'h30)};
    else if (b inside {[8'h61:8'h66]}) v = {1'b0, 4'(b - 8'h57)};
    else if (b inside {[8'h41:8'h46]}) v = {1'b0, 4'(b - 8'h37)};
    return v;
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return (b inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]});
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = 8'h30 + {4'h0, n};
    else c = 8'h57 + {4'h0, n};
    return c;
  endfunction

endpackage

[rtl/core/path_label_hex_escape_codec.sv]
// top level of the path label hex escape codec: input register, translation, result buffer
//
// in channel: one label byte per transaction (in_byte_i, is_last_i, empty_label_i);
// empty_label_i marks a label with no byte and also ends the label.
// out channel: one result per transaction (out_byte_o, byte_valid_o, label_end_o,
// label_error_o); label_error_o on the final result voids the whole label.
// cfg_we_i writes the direction (0 escape, 1 unescape) and clears the label
// state; write it only while the block is idle.
// an item is held in the input register; its results are registered in the result
// buffer and go to the out port from there. an item yields 0 to 3 results (an escaped
// byte yields 3, some items yield none); the out port gives one result per cycle
// while out_ready_i is high.
// the input register accepts a new item while results of the previous one wait.
// reset: direction escape, label at start, no items held.
// a stall on the out port holds the current result; once the input register is
// full as well, in_ready_o drops.
module path_label_hex_escape_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  input  logic       empty_label_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       label_end_o,
  output logic       label_error_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i
);
  import plhe_pkg::*;

  logic       dir_q;
  lbl_state_t st_q, st_d;
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       empty_q;
  res_t [2:0] res_q, res_d;
  logic [1:0] cnt_d;
  logic [1:0] rem_q;
  logic [1:0] idx_q;
  logic       take;
  logic       adv;
  res_t       cur;

  plhe_xlate u_xlate (
    .dir_i         (dir_q),
    .state_i       (st_q),
    .in_byte_i     (byte_q),
    .is_last_i     (last_q),
    .empty_label_i (empty_q),
    .res_cnt_o     (cnt_d),
    .res_o         (res_d),
    .state_o       (st_d)
  );

  assign take       = out_valid_o & out_ready_i;
  assign adv        = in_vld_q & ((rem_q == 2'd0) | ((rem_q == 2'd1) & out_ready_i));
  assign in_ready_o = !in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirEscape;
      st_q  <= LblClear;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
      st_q  <= LblClear;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= in_byte_i;
      last_q  <= is_last_i;
      empty_q <= empty_label_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else if (adv) begin
      rem_q <= cnt_d;
      idx_q <= 2'd0;
    end else if (take) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  assign cur           = res_q[idx_q];
  assign out_valid_o   = rem_q != 2'd0;
  assign out_byte_o    = cur.out_byte;
  assign byte_valid_o  = cur.byte_valid;
  assign label_end_o   = cur.label_end;
  assign label_error_o = cur.label_error;

  a_err_ends_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && label_error_o) |-> label_end_o)
    else $error("label error on a result that does not end the label");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (out_byte_o == 8'h00))
    else $error("bare marker carries a nonzero byte");

  a_escape_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dir_q == DirEscape) |-> (st_q.phase == PhIdle && st_q.held == 8'h00))
    else $error("escape pending while in escape mode");

  a_adv_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && rem_q != 2'd0) |-> (rem_q == 2'd1 && out_ready_i))
    else $error("result buffer overwritten before drained");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase != 2'd3)
    else $error("decode phase took an unused code");

endmodule

[rtl/core/plhe_xlate.sv]
// per-byte escape and unescape translation: result entries and next label state
module plhe_xlate (
  input  logic                        dir_i,
  input  plhe_pkg::lbl_state_t        state_i,
  input  logic [7:0]                  in_byte_i,
  input  logic                        is_last_i,
  input  logic                        empty_label_i,
  output logic [1:0]                  res_cnt_o,
  output plhe_pkg::res_t [2:0]        res_o,
  output plhe_pkg::lbl_state_t        state_o
);
  import plhe_pkg::*;

  logic       last;
  logic [1:0] ph;
  logic [4:0] lo_v;
  logic [4:0] hi_v;
  logic [1:0] n;
  res_t [2:0] e;
  lbl_state_t nxt;

  assign last = empty_label_i | is_last_i;
  assign ph   = (state_i.phase == 2'd3) ? PhIdle : state_i.phase;
  assign lo_v = hex_value(in_byte_i);
  assign hi_v = hex_value(state_i.held);

  always_comb begin
    n   = 2'd0;
    e   = '0;
    nxt = state_i;
    if (dir_i == DirEscape) begin
      if (empty_label_i) begin
        if (state_i.at_start) e[n] = mk_res(Underscore, 1'b1, 1'b1, 1'b0);
        else e[n] = mk_res(8'h00, 1'b0, 1'b1, 1'b0);
        n = n + 2'd1;
      end else if (is_alnum(in_byte_i)) begin
        e[n] = mk_res(in_byte_i, 1'b1, last, 1'b0);
        n = n + 2'd1;
      end else begin
        e[0] = mk_res(Underscore, 1'b1, 1'b0, 1'b0);
        e[1] = mk_res(hex_char(in_byte_i[7:4]), 1'b1, 1'b0, 1'b0);
        e[2] = mk_res(hex_char(in_byte_i[3:0]), 1'b1, last, 1'b0);
        n = 2'd3;
      end
    end else if (empty_label_i) begin
      e[n] = mk_res(8'h00, 1'b0, 1'b1, ph != PhIdle);
      n = n + 2'd1;
    end else begin
      case (ph)
        PhIdle: begin
          if (in_byte_i == Underscore) begin
            if (last) begin
              e[n] = mk_res(8'h00, 1'b0, 1'b1, !state_i.at_start);
              n = n + 2'd1;
            end else begin
              nxt.phase = PhUs;
            end
          end else begin
            e[n] = mk_res(in_byte_i, 1'b1, last, 1'b0);
            n = n + 2'd1;
          end
        end
        PhUs: begin
          if (last) begin
            e[n] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
            n = n + 2'd1;
          end else if (!lo_v[4]) begin
            nxt.held  = in_byte_i;
            nxt.phase = PhHex;
          end else begin
            nxt.phase = PhIdle;
            e[n] = mk_res(Underscore, 1'b1, 1'b0, 1'b0);
            n = n + 2'd1;
            if (in_byte_i == Underscore) begin
              nxt.phase = PhUs;
            end else begin
              e[n] = mk_res(in_byte_i, 1'b1, 1'b0, 1'b0);
              n = n + 2'd1;
            end
          end
        end
        PhHex: begin
          nxt.phase = PhIdle;
          nxt.held  = 8'h00;
          if (!lo_v[4] && !hi_v[4]) begin
            e[n] = mk_res({hi_v[3:0], lo_v[3:0]}, 1'b1, last, 1'b0);
            n = n + 2'd1;
          end else begin
            e[0] = mk_res(Underscore, 1'b1, 1'b0, 1'b0);
            e[1] = mk_res(state_i.held, 1'b1, 1'b0, 1'b0);
            n = 2'd2;
            if (in_byte_i == Underscore) begin
              if (last) begin
                e[n] = mk_res(8'h00, 1'b0, 1'b1, 1'b1);
                n = n + 2'd1;
              end else begin
                nxt.phase = PhUs;
              end
            end else begin
              e[n] = mk_res(in_byte_i, 1'b1, last, 1'b0);
              n = n + 2'd1;
            end
          end
        end
        default: begin
          nxt.phase = PhIdle;
        end
      endcase
    end
    if (last) nxt = LblClear;
    else nxt.at_start = 1'b0;
  end

  assign res_cnt_o = n;
  assign res_o     = e;
  assign state_o   = nxt;

endmodule
